// File: hdl/psct_pkg.sv
`timescale 1ns / 1ps

package psct_pkg;

   localparam int INTERNAL_FRAC_BITS_DEF = 24;

   localparam int ANGLE_W    = 32;
   localparam int VALUE_W    = 40;
   localparam int THRESH_W   = 16;
   localparam int LIMIT_W    = 23;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] REG_POLE_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_POLE_LIMIT     = 1'b1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd17;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 23'd1000000;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 40'h7F_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN = 40'h80_0000_0000;

   // Constants in Q.30
   localparam logic [63:0] Q30_PI      = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
   localparam logic [63:0] Q30_K1      = 64'd1367130551;
   localparam logic [63:0] Q30_K2      = 64'd435171170;
   localparam logic [63:0] Q30_CORR    = 64'd241591910;

   typedef enum logic [1:0] {
      OP_SIN = 2'd0,
      OP_COS = 2'd1,
      OP_TAN = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               clamp;
      logic               s_neg;
      logic               q_neg;
      logic [VALUE_W-1:0] trig;
   } tail_type;

   // Round a Q.30 constant to nearest in Q.frac (frac of 30 or more: returned as is)
   function automatic logic [63:0] const_q(input logic [63:0] q30, input int frac);
      logic [63:0] r;
      if (frac >= 30) begin
         r = q30;
      end else begin
         r = (q30 + (64'd1 << (29 - frac))) >> (30 - frac);
      end
      return r;
   endfunction

endpackage

// File: hdl/psct_wrap.sv
`timescale 1ns / 1ps

module psct_wrap #(
   parameter int FRAC_BITS = psct_pkg::INTERNAL_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  psct_pkg::op_type             in_op,
   input  logic signed [psct_pkg::ANGLE_W-1:0] in_angle,
   output logic                         out_valid,
   output psct_pkg::op_type             out_op,
   output logic signed [FRAC_BITS+2:0]  out_x [2]
);

   localparam int AW = FRAC_BITS + 16;
   localparam int UW = FRAC_BITS + 18;
   localparam int XW = FRAC_BITS + 3;
   localparam int QB = UW - FRAC_BITS - 2;
   localparam int NS = QB + 2;

   localparam logic [63:0] TWO  = psct_pkg::const_q(psct_pkg::Q30_TWO_PI, FRAC_BITS);
   localparam logic [63:0] PI   = psct_pkg::const_q(psct_pkg::Q30_PI, FRAC_BITS);
   localparam logic [63:0] HALF = psct_pkg::const_q(psct_pkg::Q30_HALF_PI, FRAC_BITS);
   localparam logic [63:0] BIAS =
      (((64'd1 << (FRAC_BITS + 15)) + TWO - 64'd1) / TWO) * TWO;

   logic signed [AW-1:0] a;
   logic [UW-1:0]        u_sin;
   logic [UW-1:0]        u_cos;

   logic [UW-1:0]        r_ff [2][QB+1];
   logic [UW-1:0]        r_in [2][QB+1];
   logic signed [XW-1:0] x_ff [2];
   logic signed [XW-1:0] x_in [2];
   logic signed [XW:0]   rw   [2];
   logic signed [XW:0]   rd   [2];

   logic                 valid_ff [NS];
   psct_pkg::op_type     op_ff    [NS];

   assign a     = AW'(in_angle) <<< (FRAC_BITS - 16);
   // bias by a multiple of two pi so the reduction is a plain floor modulo
   assign u_sin = UW'(a) + UW'(BIAS);
   assign u_cos = UW'(a) + UW'(HALF) + UW'(BIAS);

   always_comb begin
      r_in[0][0] = u_sin;
      r_in[1][0] = u_cos;
      for (int l = 0; l < 2; l++) begin
         for (int k = 0; k < QB; k++) begin
            r_in[l][k+1] = (r_ff[l][k] >= (UW'(TWO) << (QB - 1 - k))) ?
                           r_ff[l][k] - (UW'(TWO) << (QB - 1 - k)) : r_ff[l][k];
         end
         rw[l]   = signed'({1'b0, r_ff[l][QB][XW-1:0]});
         rd[l]   = rw[l] - (XW+1)'(TWO);
         x_in[l] = (r_ff[l][QB] > UW'(PI)) ? XW'(rd[l]) : XW'(rw[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
         x_ff <= x_in;
         op_ff[0] <= in_op;
         for (int k = 1; k < NS; k++) begin
            op_ff[k] <= op_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_op    = op_ff[NS-1];
   assign out_x     = x_ff;

endmodule

// File: hdl/psct_sine.sv
`timescale 1ns / 1ps

module psct_sine #(
   parameter int FRAC_BITS = psct_pkg::INTERNAL_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  psct_pkg::op_type            in_op,
   input  logic signed [FRAC_BITS+2:0] in_x [2],
   output logic                        out_valid,
   output psct_pkg::op_type            out_op,
   output logic signed [FRAC_BITS+7:0] out_w [2]
);

   localparam int F   = FRAC_BITS;
   localparam int MW  = F + 2;
   localparam int YW  = F + 4;
   localparam int VW  = F + 7;
   localparam int WW  = F + 8;
   localparam int NS  = 7;

   localparam logic [63:0] K1   = psct_pkg::const_q(psct_pkg::Q30_K1, F);
   localparam logic [63:0] K2   = psct_pkg::const_q(psct_pkg::Q30_K2, F);
   localparam logic [63:0] CORR = psct_pkg::const_q(psct_pkg::Q30_CORR, F);
   localparam logic [63:0] HALF = 64'd1 << (F - 1);

   // stage 1
   logic               s1_sx    [2];
   logic [2*F+2:0]     s1_p1raw [2];
   logic [2*F+3:0]     s1_traw  [2];
   logic [MW-1:0]      ax       [2];
   // stage 2
   logic               s2_sx    [2];
   // (4/pi) x reaches 4.0 and a hair above at x = pi
   logic [F+2:0]       s2_p1    [2];
   logic [2*F+3:0]     s2_umraw [2];
   logic [2*F+2:0]     p1sum    [2];
   logic [2*F+3:0]     tsum     [2];
   logic [F+3:0]       t        [2];
   // stage 3
   logic signed [YW-1:0] s3_y   [2];
   logic [2*F+3:0]     usum     [2];
   logic [F+3:0]       um       [2];
   // stage 4
   logic signed [YW-1:0] s4_y   [2];
   logic [2*F+5:0]     s4_yyraw [2];
   logic [F+2:0]       ay       [2];
   // stage 5
   logic signed [YW-1:0] s5_y   [2];
   logic signed [VW-1:0] s5_v   [2];
   logic [2*F+5:0]     yysum    [2];
   logic [F+5:0]       yy       [2];
   // stage 6
   logic signed [YW-1:0] s6_y   [2];
   logic               s6_sv    [2];
   logic [2*F+5:0]     s6_cmraw [2];
   logic [F+5:0]       av       [2];
   // stage 7
   logic signed [WW-1:0] s7_w   [2];
   logic [2*F+5:0]     cmsum    [2];
   logic [F+5:0]       cm       [2];

   logic               valid_ff [NS];
   psct_pkg::op_type   op_ff    [NS];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         ax[l]    = MW'(in_x[l] < 0 ? -in_x[l] : in_x[l]);
         p1sum[l] = s1_p1raw[l] + (2*F+3)'(HALF);
         tsum[l]  = s1_traw[l] + (2*F+4)'(HALF);
         t[l]     = tsum[l][F +: F+4];
         usum[l]  = s2_umraw[l] + (2*F+4)'(HALF);
         um[l]    = usum[l][F +: F+4];
         ay[l]    = (F+3)'(s3_y[l] < 0 ? -s3_y[l] : s3_y[l]);
         yysum[l] = s4_yyraw[l] + (2*F+6)'(HALF);
         yy[l]    = yysum[l][F +: F+6];
         av[l]    = (F+6)'(s5_v[l] < 0 ? -s5_v[l] : s5_v[l]);
         cmsum[l] = s6_cmraw[l] + (2*F+6)'(HALF);
         cm[l]    = cmsum[l][F +: F+6];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            s1_sx[l]    <= in_x[l] < 0;
            s1_p1raw[l] <= (2*F+3)'(ax[l]) * (2*F+3)'(K1);
            s1_traw[l]  <= (2*F+4)'(ax[l]) * (2*F+4)'(ax[l]);

            s2_sx[l]    <= s1_sx[l];
            s2_p1[l]    <= p1sum[l][F +: F+3];
            s2_umraw[l] <= (2*F+4)'(t[l]) * (2*F+4)'(K2);

            s3_y[l] <= s2_sx[l] ? YW'(um[l]) - YW'(s2_p1[l])
                                : YW'(s2_p1[l]) - YW'(um[l]);

            s4_y[l]     <= s3_y[l];
            s4_yyraw[l] <= (2*F+6)'(ay[l]) * (2*F+6)'(ay[l]);

            s5_y[l] <= s4_y[l];
            s5_v[l] <= (s4_y[l] < 0 ? -VW'(yy[l]) : VW'(yy[l])) - VW'(s4_y[l]);

            s6_y[l]     <= s5_y[l];
            s6_sv[l]    <= s5_v[l] < 0;
            s6_cmraw[l] <= (2*F+6)'(av[l]) * (2*F+6)'(CORR);

            s7_w[l] <= (s6_sv[l] ? -WW'(cm[l]) : WW'(cm[l])) + WW'(s6_y[l]);
         end
         op_ff[0] <= in_op;
         for (int k = 1; k < NS; k++) begin
            op_ff[k] <= op_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_op    = op_ff[NS-1];
   assign out_w     = s7_w;

endmodule

// File: hdl/psct_div.sv
`timescale 1ns / 1ps

module psct_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 31,
   parameter int PAY_W = 45
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [PAY_W-1:0] out_pay
);

   // one quotient bit per stage, MSB first
   logic [DEN_W-1:0] rem_ff  [NUM_W];
   logic [NUM_W-1:0] nq_ff   [NUM_W];
   logic [DEN_W-1:0] den_ff  [NUM_W];
   logic [PAY_W-1:0] pay_ff  [NUM_W];
   logic             valid_ff[NUM_W];

   logic [DEN_W-1:0] src_rem [NUM_W];
   logic [NUM_W-1:0] src_nq  [NUM_W];
   logic [DEN_W-1:0] src_den [NUM_W];
   logic [DEN_W:0]   tmp     [NUM_W];
   logic             ge      [NUM_W];
   logic [DEN_W-1:0] rem_in  [NUM_W];
   logic [NUM_W-1:0] nq_in   [NUM_W];

   always_comb begin
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            src_rem[k] = '0;
            src_nq[k]  = in_num;
            src_den[k] = in_den;
         end else begin
            src_rem[k] = rem_ff[k-1];
            src_nq[k]  = nq_ff[k-1];
            src_den[k] = den_ff[k-1];
         end
         tmp[k]    = {src_rem[k], src_nq[k][NUM_W-1]};
         ge[k]     = tmp[k] >= {1'b0, src_den[k]};
         rem_in[k] = ge[k] ? DEN_W'(tmp[k] - {1'b0, src_den[k]}) : DEN_W'(tmp[k]);
         nq_in[k]  = {src_nq[k][NUM_W-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         nq_ff  <= nq_in;
         den_ff <= src_den;
         pay_ff[0] <= in_pay;
         for (int k = 1; k < NUM_W; k++) begin
            pay_ff[k] <= pay_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NUM_W; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_pay   = pay_ff[NUM_W-1];

endmodule

// File: hdl/parabolic_sine_cosine_tangent.sv
`timescale 1ns / 1ps

// Parabolic sine / cosine / tangent, fully pipelined.
// Request channel (req_*): tuser carries the op (sine, cosine, tangent), tdata
// the signed Q15.16 angle in radians. Response channel (rsp_*): tdata is the
// signed Q23.16 result, tuser flags a tangent that was clamped near a pole.
// CSR port: pole_threshold (index 0) and pole_limit (index 1); write only
// while no request is in flight.
// In order, a request passes the modulo two pi reduction, the sine
// polynomial, operand prep, the bit-per-stage tangent divider and the
// output register. Sine and cosine ride the same pipe, so order is kept.
// One request enters per cycle while the pipe is not held; the divider's
// stage count sets the depth, not the rate.
// Reset clears all valid bits and loads the register defaults (threshold 17,
// limit 1000000). When the receiver holds off rsp_tready with a response
// waiting, the whole pipe holds and req_tready drops; nothing is lost or
// repeated.
module parabolic_sine_cosine_tangent #(
   parameter int INTERNAL_FRAC_BITS = psct_pkg::INTERNAL_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // [31:0] angle
   input  logic [1:0]                        req_tuser,   // [1:0] op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,   // [39:0] value
   output logic [0:0]                        rsp_tuser,   // [0] pole_clamped
   input  logic                              csr_we,
   input  logic [psct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [psct_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int F   = INTERNAL_FRAC_BITS;
   localparam int XW  = F + 3;
   localparam int WW  = F + 8;
   localparam int MSW = F + 7;
   localparam int NW  = F + 24;
   localparam int TW  = (F > 24) ? 16 + F - 24 : 16;
   localparam int PW  = $bits(psct_pkg::tail_type);
   localparam int VW  = psct_pkg::VALUE_W;
   localparam logic [63:0] HQ = (F > 16) ? (64'd1 << (F > 16 ? F - 17 : 0)) : 64'd0;

   logic                          pipe_en;

   logic [psct_pkg::THRESH_W-1:0] thresh_ff;
   logic [psct_pkg::LIMIT_W-1:0]  limit_ff;

   logic                          w_valid;
   psct_pkg::op_type              w_op;
   logic signed [XW-1:0]          w_x [2];

   logic                          s_valid;
   psct_pkg::op_type              s_op;
   logic signed [WW-1:0]          s_w [2];

   logic [MSW-1:0]                ms;
   logic [MSW-1:0]                mc;
   logic signed [WW-1:0]          pick;
   logic [MSW-1:0]                mpick;
   logic [MSW:0]                  psum;
   logic [23:0]                   pq16;
   logic [TW-1:0]                 thr_q;
   psct_pkg::tail_type            tail_in;

   logic                          p_valid_ff;
   logic [NW-1:0]                 num_ff;
   logic [MSW-1:0]                den_ff;
   psct_pkg::tail_type            tail_ff;

   logic                          d_valid;
   logic [NW-1:0]                 d_quo;
   logic [PW-1:0]                 d_pay;
   psct_pkg::tail_type            d_tail;

   logic [VW-1:0]                 lim;
   logic [VW-1:0]                 value_in;
   logic                          clamp_in;

   logic                          rsp_tvalid_ff;
   logic [VW-1:0]                 rsp_tdata_ff;
   logic                          rsp_tuser_ff;

   // the whole pipe advances unless a response is stuck at the output
   assign pipe_en    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= psct_pkg::THRESH_RESET;
         limit_ff  <= psct_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            psct_pkg::REG_POLE_THRESHOLD: thresh_ff <= csr_wdata[psct_pkg::THRESH_W-1:0];
            psct_pkg::REG_POLE_LIMIT:     limit_ff  <= csr_wdata[psct_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   psct_wrap #(.FRAC_BITS(F)) u_wrap (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (req_tvalid),
      .in_op    (psct_pkg::op_type'(req_tuser)),
      .in_angle (signed'(req_tdata)),
      .out_valid(w_valid),
      .out_op   (w_op),
      .out_x    (w_x)
   );

   psct_sine #(.FRAC_BITS(F)) u_sine (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (w_valid),
      .in_op    (w_op),
      .in_x     (w_x),
      .out_valid(s_valid),
      .out_op   (s_op),
      .out_w    (s_w)
   );

   // operand prep: magnitudes, pole test, sine/cosine rounded to Q.16
   always_comb begin
      ms    = MSW'(s_w[0] < 0 ? -s_w[0] : s_w[0]);
      mc    = MSW'(s_w[1] < 0 ? -s_w[1] : s_w[1]);
      pick  = (s_op == psct_pkg::OP_COS) ? s_w[1] : s_w[0];
      mpick = MSW'(pick < 0 ? -pick : pick);
      psum  = (MSW+1)'(mpick) + (MSW+1)'(HQ);
      pq16  = psum[(F-16) +: 24];
      if (F >= 24) begin
         thr_q = TW'(thresh_ff) << (F >= 24 ? F - 24 : 0);
      end else begin
         thr_q = TW'(thresh_ff >> (F < 24 ? 24 - F : 0));
      end
      tail_in.op    = s_op;
      tail_in.clamp = (s_op == psct_pkg::OP_TAN) && (mc == '0 || mc < MSW'(thr_q));
      tail_in.s_neg = s_w[0] < 0;
      tail_in.q_neg = (s_w[0] < 0) != (s_w[1] < 0);
      tail_in.trig  = (pick < 0) ? -VW'(pq16) : VW'(pq16);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         num_ff  <= (NW'(ms) << 16) + NW'(mc >> 1);
         den_ff  <= mc;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         p_valid_ff <= s_valid;
      end
   end

   psct_div #(.NUM_W(NW), .DEN_W(MSW), .PAY_W(PW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (p_valid_ff),
      .in_num   (num_ff),
      .in_den   (den_ff),
      .in_pay   (PW'(tail_ff)),
      .out_valid(d_valid),
      .out_quo  (d_quo),
      .out_pay  (d_pay)
   );

   assign d_tail = psct_pkg::tail_type'(d_pay);
   assign lim    = {1'b0, limit_ff, 16'd0};

   always_comb begin
      value_in = '0;
      clamp_in = 1'b0;
      unique case (d_tail.op)
         psct_pkg::OP_SIN, psct_pkg::OP_COS: begin
            value_in = d_tail.trig;
         end
         psct_pkg::OP_TAN: begin
            if (d_tail.clamp) begin
               clamp_in = 1'b1;
               value_in = d_tail.s_neg ? -lim : lim;
            end else if (d_tail.q_neg) begin
               value_in = (d_quo > NW'(psct_pkg::VALUE_MAX) + NW'(1)) ?
                          psct_pkg::VALUE_MIN : -d_quo[VW-1:0];
            end else begin
               value_in = (d_quo > NW'(psct_pkg::VALUE_MAX)) ?
                          psct_pkg::VALUE_MAX : d_quo[VW-1:0];
            end
         end
         default: begin
            value_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_tdata_ff <= value_in;
         rsp_tuser_ff <= clamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_tvalid_ff <= d_valid;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int HOLD_LEN = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [psct_pkg::VALUE_W-1:0] value;
      logic                         clamped;
   } result_type;

   class scoreboard_type;
      longint unsigned thresh;
      longint unsigned limit;
      result_type      pending[$];
      int              errors;

      function new();
         thresh = 17;
         limit = 1000000;
         errors = 0;
      endfunction

      function longint rnd_shr(longint unsigned m, int s);
         return (m + (64'd1 << (s - 1))) >> s;
      endfunction

      function longint unsigned mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      // round a Q.30 constant to Q.24
      function longint cq(longint unsigned q30);
         return rnd_shr(q30, 6);
      endfunction

      function longint mul_q24(longint a, longint b);
         longint r;
         r = rnd_shr(mag(a) * mag(b), 24);
         return ((a < 0) != (b < 0)) ? -r : r;
      endfunction

      function longint parabola(longint a);
         longint two_pi, x, ax, y, ay;
         two_pi = cq(psct_pkg::Q30_TWO_PI);
         x = a % two_pi;
         if (x < 0) x += two_pi;
         if (x > cq(psct_pkg::Q30_PI)) x -= two_pi;
         ax = x < 0 ? -x : x;
         y = mul_q24(cq(psct_pkg::Q30_K1), x)
             - mul_q24(cq(psct_pkg::Q30_K2), mul_q24(x, ax));
         ay = y < 0 ? -y : y;
         return mul_q24(cq(psct_pkg::Q30_CORR), mul_q24(y, ay) - y) + y;
      endfunction

      function longint to_q16(longint v);
         longint r;
         r = rnd_shr(mag(v), 8);
         return v < 0 ? -r : r;
      endfunction

      function void note(logic [1:0] op, logic [31:0] angle);
         result_type      res;
         longint          a, s, c, v;
         longint unsigned mc, q;
         a = longint'(signed'(angle)) * 256;
         v = 0;
         res.clamped = 1'b0;
         if (op == psct_pkg::OP_SIN) begin
            v = to_q16(parabola(a));
         end else if (op == psct_pkg::OP_COS) begin
            v = to_q16(parabola(a + cq(psct_pkg::Q30_HALF_PI)));
         end else if (op == psct_pkg::OP_TAN) begin
            s = parabola(a);
            c = parabola(a + cq(psct_pkg::Q30_HALF_PI));
            mc = mag(c);
            if (mc == 0 || mc < thresh) begin
               v = s >= 0 ? longint'(limit << 16) : -longint'(limit << 16);
               res.clamped = 1'b1;
            end else begin
               q = ((mag(s) << 16) + (mc >> 1)) / mc;
               if ((s < 0) != (c < 0))
                  v = q > 64'd549755813888 ? -64'sd549755813888 : -longint'(q);
               else
                  v = q > 64'd549755813887 ? 64'sd549755813887 : longint'(q);
            end
         end
         res.value = v[psct_pkg::VALUE_W-1:0];
         pending.push_back(res);
      endfunction

      task report(string msg);
         $display("tb: mismatch: %s", msg);
         errors++;
      endtask

      task check(logic [psct_pkg::VALUE_W-1:0] value, logic clamped);
         result_type want;
         if (pending.size() == 0) begin
            report($sformatf("response with nothing pending, value %h", value));
         end else begin
            want = pending.pop_front();
            if (value !== want.value)
               report($sformatf("value %h, want %h", value, want.value));
            if (clamped !== want.clamped)
               report($sformatf("pole flag %b, want %b", clamped, want.clamped));
         end
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid, req_tready;
   logic [31:0]                     req_tdata;
   logic [1:0]                      req_tuser;
   logic                            rsp_tvalid, rsp_tready;
   logic [39:0]                     rsp_tdata;
   logic [0:0]                      rsp_tuser;
   logic                            csr_we;
   logic [psct_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [psct_pkg::CSR_DATA_W-1:0] csr_wdata;

   scoreboard_type sb = new();
   int             idle_cycles = 0;
   int             rsp_count = 0;

   always #5 clock = ~clock;

   parabolic_sine_cosine_tangent i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   task send(logic [1:0] op, logic [31:0] angle);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= angle;
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      sb.note(op, angle);
   endtask

   task write_reg(logic [psct_pkg::CSR_IDX_W-1:0] idx,
                  logic [psct_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == psct_pkg::REG_POLE_THRESHOLD)
         sb.thresh = data[psct_pkg::THRESH_W-1:0];
      else
         sb.limit = data;
      @(posedge clock);
   endtask

   task wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // drain the pipe, then retune both registers
   task set_regs(logic [psct_pkg::THRESH_W-1:0] thresh,
                 logic [psct_pkg::LIMIT_W-1:0] limit);
      req_tvalid <= 1'b0;
      wait_drained();
      write_reg(psct_pkg::REG_POLE_THRESHOLD, psct_pkg::CSR_DATA_W'(thresh));
      write_reg(psct_pkg::REG_POLE_LIMIT, limit);
   endtask

   function logic [31:0] pick_angle();
      int k;
      case ($urandom_range(0, 3))
         0: pick_angle = $urandom;
         1: pick_angle = $urandom_range(0, 1048576) - 524288;
         2: begin
            // near a multiple of half pi; the odd ones are where tangent hits its poles
            k = $urandom_range(0, 40) - 20;
            pick_angle = k * 102944 + $urandom_range(0, 128) - 64;
         end
         default: pick_angle = $urandom_range(0, 65536) - 32768;
      endcase
   endfunction

   // receiver: random stalls, one long hold-off, and a stretch with none
   initial begin
      int n;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         n = $urandom_range(0, 8);
         if (rsp_count == 500) n = HOLD_LEN;
         else if (rsp_count > 900 && rsp_count < 1100) n = 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check(rsp_tdata, rsp_tuser[0]);
      if (reset || (rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] edge_angles[12];
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= psct_pkg::OP_SIN;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero, field extremes, around plus and minus pi and the cosine zero
      edge_angles = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd205887, -32'd205887,
                      32'd205888, -32'd205888, 32'd102944, 32'd102943, -32'd102944,
                      32'd1, 32'hFFFF_FFFF};
      foreach (edge_angles[i]) begin
         send(psct_pkg::OP_SIN, edge_angles[i]);
         send(psct_pkg::OP_COS, edge_angles[i]);
         if (i < 9) send(psct_pkg::OP_TAN, edge_angles[i]);
      end
      send(OP_NONE, 32'h1234_5678);
      send(OP_NONE, 32'hFFFF_FFFF);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: set_regs(16'd0, 23'd1);
            2: set_regs(16'hFFFF, 23'h7F_FFFF);
            3: set_regs(psct_pkg::THRESH_W'($urandom),
                        psct_pkg::LIMIT_W'($urandom_range(1, 8388607)));
            default: ;
         endcase
         repeat (475) send(2'($urandom_range(0, 3)), pick_angle());
         send(psct_pkg::OP_TAN, 32'd102944);
      end
      req_tvalid <= 1'b0;

      wait_drained();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// File: parabolic_sine_cosine_tangent.f
hdl/psct_pkg.sv
hdl/psct_wrap.sv
hdl/psct_sine.sv
hdl/psct_div.sv
hdl/parabolic_sine_cosine_tangent.sv
tb/sv/tb.sv
